// ===== rtl/core/bgc_pkg.sv =====
// Shared types and constants of the button gesture classifier.
package bgc_pkg;

  localparam int unsigned AgeW = 16;
  localparam int unsigned CfgW = 16;
  localparam int unsigned CfgAddrW = 2;
  localparam logic [AgeW-1:0] AgeMax = {AgeW{1'b1}};

  // Gesture codes
  localparam logic [1:0] GestNone   = 2'd0;
  localparam logic [1:0] GestSingle = 2'd1;
  localparam logic [1:0] GestDouble = 2'd2;
  localparam logic [1:0] GestLong   = 2'd3;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] RegClickMin = 2'd0;
  localparam logic [CfgAddrW-1:0] RegClickMax = 2'd1;
  localparam logic [CfgAddrW-1:0] RegWindow   = 2'd2;
  localparam logic [CfgAddrW-1:0] RegLongMax  = 2'd3;

  // Configuration register reset values
  localparam logic [CfgW-1:0] ClickMinRst = 16'd30;
  localparam logic [CfgW-1:0] ClickMaxRst = 16'd800;
  localparam logic [CfgW-1:0] WindowRst   = 16'd350;
  localparam logic [CfgW-1:0] LongMaxRst  = 16'd5000;

  typedef struct packed {
    logic [CfgW-1:0] click_min;
    logic [CfgW-1:0] click_max;
    logic [CfgW-1:0] window;
    logic [CfgW-1:0] long_max;
  } cfg_t;

  typedef struct packed {
    logic            last_level;
    logic [AgeW-1:0] press_age;
    logic            click_waiting;
    logic [AgeW-1:0] waiting_age;
  } state_t;

endpackage

// ===== rtl/core/bgc_classify.sv =====
// One-tick classification: ages advance, edges resolve, a pending click expires.
module bgc_classify (
  input  bgc_pkg::cfg_t   cfg_i,
  input  bgc_pkg::state_t st_i,
  input  logic            level_i,
  output bgc_pkg::state_t st_o,
  output logic [1:0]      gesture_o
);

  logic [bgc_pkg::AgeW-1:0] press_adv;
  logic [bgc_pkg::AgeW-1:0] wait_adv;
  logic                     waiting_mid;
  logic [bgc_pkg::AgeW-1:0] wait_mid;
  logic [1:0]               gest_mid;
  logic                     is_click;
  logic                     is_long;

  // Advance saturating ages
  always_comb begin
    press_adv = st_i.press_age;
    if (!st_i.last_level && st_i.press_age != bgc_pkg::AgeMax) begin
      press_adv = st_i.press_age + 1'b1;
    end
    wait_adv = st_i.waiting_age;
    if (st_i.click_waiting && st_i.waiting_age != bgc_pkg::AgeMax) begin
      wait_adv = st_i.waiting_age + 1'b1;
    end
  end

  assign is_click = (press_adv > cfg_i.click_min) && (press_adv < cfg_i.click_max);
  assign is_long  = (press_adv >= cfg_i.click_max) && (press_adv < cfg_i.long_max);

  // Resolve edges, then test the pending click for expiry
  always_comb begin
    st_o.last_level = level_i;
    st_o.press_age  = press_adv;
    waiting_mid     = st_i.click_waiting;
    wait_mid        = wait_adv;
    gest_mid        = bgc_pkg::GestNone;
    if (st_i.last_level && !level_i) begin
      st_o.press_age = '0;
    end else if (!st_i.last_level && level_i) begin
      if (is_click) begin
        if (st_i.click_waiting && wait_adv < cfg_i.window) begin
          waiting_mid = 1'b0;
          gest_mid    = bgc_pkg::GestDouble;
        end else begin
          waiting_mid = 1'b1;
        end
        wait_mid = '0;
      end else if (is_long) begin
        waiting_mid = 1'b0;
        wait_mid    = '0;
        gest_mid    = bgc_pkg::GestLong;
      end
    end
    st_o.click_waiting = waiting_mid;
    st_o.waiting_age   = wait_mid;
    gesture_o          = gest_mid;
    if (waiting_mid && wait_mid >= cfg_i.window) begin
      st_o.click_waiting = 1'b0;
      st_o.waiting_age   = '0;
      gesture_o          = bgc_pkg::GestSingle;
    end
  end

endmodule

// ===== rtl/core/button_gesture_classifier_core.sv =====
// Button gesture classifier: single, double and long press from a sampled pin.
//
// Input stream: one word per millisecond tick, tdata bit 0 is the pin level
// (0 pressed, 1 released). Every accepted word yields exactly one result word
// on the output stream, tdata bits 1:0 holding the gesture code (none,
// single click, double click, long press).
// The result of an accepted word is registered. One word is accepted per
// cycle while the skid stage is empty; the press and pending click state
// updates in a single pass of compares and 16-bit increments.
// An output register plus a one-word skid stage sit on the result side, so
// input ready depends only on the skid stage being empty; when the receiver
// stalls, one more word is taken and then input ready drops until a result
// drains.
// Configuration: write enable, 2-bit register index and 16-bit data, taken
// on any edge with the enable high; write only while no results are pending.
// Reset clears state to released with no pending click, restores the
// register defaults and empties both output stages.
module button_gesture_classifier_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bgc_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [bgc_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [0] button_level
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata   // [1:0] gesture
);

  bgc_pkg::cfg_t   cfg_q;
  bgc_pkg::state_t st_q;
  bgc_pkg::state_t st_d;
  logic [1:0]      gest_d;
  logic            in_acc;
  logic            out_take;
  logic            out_valid_q;
  logic [1:0]      out_gest_q;
  logic            skid_valid_q;
  logic [1:0]      skid_gest_q;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_take      = out_valid_q && m_axis_tready;
  assign s_axis_tready = !skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_gest_q};

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.click_min <= bgc_pkg::ClickMinRst;
      cfg_q.click_max <= bgc_pkg::ClickMaxRst;
      cfg_q.window    <= bgc_pkg::WindowRst;
      cfg_q.long_max  <= bgc_pkg::LongMaxRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        bgc_pkg::RegClickMin: cfg_q.click_min <= cfg_wdata_i;
        bgc_pkg::RegClickMax: cfg_q.click_max <= cfg_wdata_i;
        bgc_pkg::RegWindow:   cfg_q.window    <= cfg_wdata_i;
        bgc_pkg::RegLongMax:  cfg_q.long_max  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bgc_classify u_classify (
    .cfg_i     (cfg_q),
    .st_i      (st_q),
    .level_i   (s_axis_tdata[0]),
    .st_o      (st_d),
    .gesture_o (gest_d)
  );

  // Advance press state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.last_level    <= 1'b1;
      st_q.press_age     <= '0;
      st_q.click_waiting <= 1'b0;
      st_q.waiting_age   <= '0;
    end else if (in_acc) begin
      st_q <= st_d;
    end
  end

  // Output register and skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_acc) begin
        if (out_valid_q && !m_axis_tready) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_gest_q <= skid_gest_q;
      end
    end else if (in_acc) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_gest_q <= gest_d;
      end else begin
        out_gest_q <= gest_d;
      end
    end
  end

  // Checks
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a word while output register is empty");

  a_double_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && gest_d == bgc_pkg::GestDouble) |-> st_q.click_waiting)
    else $error("double click without a pending click");

  a_gesture_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && gest_d != bgc_pkg::GestNone) |=> !st_q.click_waiting)
    else $error("pending click survives a reported gesture");

  a_press_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && st_q.last_level && !s_axis_tdata[0]) |=> (st_q.press_age == '0))
    else $error("press age not restarted on press");

endmodule
